FILE: rtl/rotated_2bpp_pixel_writer_macros.svh
// assertion macros shared by the pixel writer rtl
`ifndef ROTATED_2BPP_PIXEL_WRITER_MACROS_SVH
`define ROTATED_2BPP_PIXEL_WRITER_MACROS_SVH

// condition in this cycle implies a consequence in the same cycle
`define R2P_ASSERT_IMP(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("pixel writer check failed");

// condition in this cycle implies a consequence in the next cycle
`define R2P_ASSERT_NXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("pixel writer check failed");

`endif

FILE: rtl/rot2bpp_pkg.sv
`timescale 1ns / 1ps

package rot2bpp_pkg;

    // panel geometry
    localparam int PANEL_WIDTH  = 800;
    localparam int PANEL_HEIGHT = 480;
    localparam int STRIDE       = (PANEL_WIDTH + 3) / 4;
    localparam int FB_BYTES     = STRIDE * PANEL_HEIGHT;

    // field widths
    localparam int POS_W   = 12;
    localparam int COORD_W = 11;
    localparam int CLIP_W  = 10;
    localparam int INDEX_W = 17;
    localparam int CFG_W   = 10;

    // canvas bounds, one bit wider than a coordinate so 2048 still fits
    localparam logic [POS_W-1:0] PW_BOUND = POS_W'(PANEL_WIDTH);
    localparam logic [POS_W-1:0] PH_BOUND = POS_W'(PANEL_HEIGHT);
    localparam logic [POS_W-1:0] PW_LAST  = POS_W'(PANEL_WIDTH - 1);
    localparam logic [POS_W-1:0] PH_LAST  = POS_W'(PANEL_HEIGHT - 1);
    localparam logic [INDEX_W-1:0] STRIDE_K = INDEX_W'(STRIDE);
    localparam logic [INDEX_W-1:0] FB_LIMIT = INDEX_W'(FB_BYTES);

    localparam logic [7:0] LANE_BASE = 8'h03;

    // rotation codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_ROTATION    = 2'd0;
    localparam logic [1:0] REG_CLIP_ENABLE = 2'd1;
    localparam logic [1:0] REG_CLIP_TOP    = 2'd2;
    localparam logic [1:0] REG_CLIP_BOTTOM = 2'd3;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [1:0]              gray;
    } plot_t;

    typedef struct packed {
        logic               write_enable;
        logic [INDEX_W-1:0] byte_index;
        logic [7:0]         lane_mask;
        logic [7:0]         lane_value;
    } pix_write_t;

endpackage

FILE: rtl/rotated_2bpp_pixel_writer.sv
`timescale 1ns / 1ps
// channel   | direction | handshake              | payload
// plot      | in        | plot_valid, plot_ready | plot (pos_x, pos_y, gray)
// wr        | out       | wr_valid, wr_ready     | wr (write_enable, byte_index, lane_mask, lane_value)
// cfg       | in        | cfg_write              | cfg_index, cfg_data
//
// three register stages: clip and rotate, row multiply and lane select, address add.
// one request per cycle while wr_ready is high; wr_valid is the stage 3 valid register.
// the row multiply by the byte stride sets the depth of the middle stage.
// rst_n clears the stage valids and the configuration registers.
// a stall on wr_ready holds each full stage with no empty stage after it; empty stages still fill.
`include "rotated_2bpp_pixel_writer_macros.svh"

module rotated_2bpp_pixel_writer
    import rot2bpp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             plot_valid,
    output logic             plot_ready,
    input  plot_t            plot,
    output logic             wr_valid,
    input  logic             wr_ready,
    output pix_write_t       wr
);

    // configuration registers
    logic [1:0]        rotation_reg;
    logic              clip_enable_reg;
    logic [CLIP_W-1:0] clip_top_reg;
    logic [CLIP_W-1:0] clip_bottom_reg;

    // pipeline valids
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s1_adv;
    logic s2_adv;
    logic s3_adv;

    // stage 1 payload
    logic               s1_pass_reg;
    logic [COORD_W-1:0] s1_px_reg;
    logic [COORD_W-1:0] s1_py_reg;
    logic [1:0]         s1_gray_reg;

    // stage 2 payload
    logic               s2_pass_reg;
    logic [INDEX_W-1:0] s2_row_reg;
    logic [COORD_W-3:0] s2_col_reg;
    logic [7:0]         s2_mask_reg;
    logic [7:0]         s2_value_reg;

    // stage 3 payload
    pix_write_t s3_reg;

    // stage 1 combinational terms
    logic              portrait;
    logic [POS_W-1:0]  lw;
    logic [POS_W-1:0]  lh;
    logic [POS_W-1:0]  ux;
    logic [POS_W-1:0]  uy;
    logic              canvas_ok;
    logic              window_ok;
    logic [POS_W-1:0]  px_full;
    logic [POS_W-1:0]  py_full;
    logic [2:0]        lane_shift;

    // stall chain: a stage moves when it is empty or the next one moves
    assign s3_adv     = !s3_valid_reg || wr_ready;
    assign s2_adv     = !s2_valid_reg || s3_adv;
    assign s1_adv     = !s1_valid_reg || s2_adv;
    assign plot_ready = s1_adv;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg    <= ROT_0;
            clip_enable_reg <= 1'b0;
            clip_top_reg    <= '0;
            clip_bottom_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ROTATION:    rotation_reg    <= cfg_data[1:0];
                REG_CLIP_ENABLE: clip_enable_reg <= cfg_data[0];
                REG_CLIP_TOP:    clip_top_reg    <= cfg_data[CLIP_W-1:0];
                REG_CLIP_BOTTOM: clip_bottom_reg <= cfg_data[CLIP_W-1:0];
            endcase
        end
    end

    // canvas and window clip, rotation to panel space
    always_comb
    begin
        portrait  = (rotation_reg == ROT_90) || (rotation_reg == ROT_270);
        lw        = portrait ? PH_BOUND : PW_BOUND;
        lh        = portrait ? PW_BOUND : PH_BOUND;
        ux        = plot.pos_x;
        uy        = plot.pos_y;
        canvas_ok = !ux[POS_W-1] && !uy[POS_W-1] && (ux < lw) && (uy < lh);
        window_ok = !clip_enable_reg
                    || ((uy >= POS_W'(clip_top_reg)) && (uy < POS_W'(clip_bottom_reg)));
        unique case (rotation_reg)
            ROT_90:
            begin
                px_full = PW_LAST - uy;
                py_full = ux;
            end
            ROT_180:
            begin
                px_full = PW_LAST - ux;
                py_full = PH_LAST - uy;
            end
            ROT_270:
            begin
                px_full = uy;
                py_full = PH_LAST - ux;
            end
            default:
            begin
                px_full = ux;
                py_full = uy;
            end
        endcase
    end

    // a point inside the rotated canvas always lands inside the panel
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_pass_reg <= canvas_ok && window_ok;
            s1_px_reg   <= px_full[COORD_W-1:0];
            s1_py_reg   <= py_full[COORD_W-1:0];
            s1_gray_reg <= plot.gray;
        end
    end

    // leftmost pixel in the high bits
    assign lane_shift = {~s1_px_reg[1:0], 1'b0};

    // row offset and lane
    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            s2_pass_reg  <= s1_pass_reg;
            s2_row_reg   <= INDEX_W'(s1_py_reg) * STRIDE_K;
            s2_col_reg   <= s1_px_reg[COORD_W-1:2];
            s2_mask_reg  <= LANE_BASE << lane_shift;
            s2_value_reg <= {6'b0, s1_gray_reg} << lane_shift;
        end
    end

    // byte address, clipped points give an all-zero request
    always_ff @(posedge clk)
    begin
        if (s3_adv)
        begin
            s3_reg.write_enable <= s2_pass_reg;
            s3_reg.byte_index   <= s2_pass_reg ? (s2_row_reg + INDEX_W'(s2_col_reg)) : '0;
            s3_reg.lane_mask    <= s2_pass_reg ? s2_mask_reg : '0;
            s3_reg.lane_value   <= s2_pass_reg ? s2_value_reg : '0;
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= plot_valid;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_adv)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    assign wr_valid = s3_valid_reg;
    assign wr       = s3_reg;

    // checks
    `R2P_ASSERT_IMP(a_lane_one_hot, clk, rst_n, wr_valid && wr.write_enable, (wr.lane_mask == 8'hC0) || (wr.lane_mask == 8'h30) || (wr.lane_mask == 8'h0C) || (wr.lane_mask == 8'h03))
    `R2P_ASSERT_IMP(a_value_in_lane, clk, rst_n, wr_valid, (wr.lane_value & ~wr.lane_mask) == 8'h00)
    `R2P_ASSERT_IMP(a_clipped_zero, clk, rst_n, wr_valid && !wr.write_enable, (wr.byte_index == '0) && (wr.lane_mask == 8'h00) && (wr.lane_value == 8'h00))
    `R2P_ASSERT_IMP(a_index_in_fb, clk, rst_n, wr_valid && wr.write_enable, wr.byte_index < FB_LIMIT)
    `R2P_ASSERT_NXT(a_fill_after_accept, clk, rst_n, plot_valid && plot_ready, s1_valid_reg)

endmodule
